// ===== rtl/core/tds_pkg.sv =====
package tds_pkg;

    // Door state machine, one-hot.
    typedef enum logic [6:0] {
        ST_READY   = 7'b000_0001,
        ST_OPENED  = 7'b000_0010,
        ST_OPENING = 7'b000_0100,
        ST_CLOSING = 7'b000_1000,
        ST_TIGHT   = 7'b001_0000,
        ST_CLOSED  = 7'b010_0000,
        ST_FAULT   = 7'b100_0000
    } door_state_t;

    // Status codes as they appear on the result ports.
    localparam logic [2:0] STATUS_READY   = 3'd0;
    localparam logic [2:0] STATUS_OPENED  = 3'd1;
    localparam logic [2:0] STATUS_OPENING = 3'd2;
    localparam logic [2:0] STATUS_CLOSING = 3'd3;
    localparam logic [2:0] STATUS_TIGHT   = 3'd4;
    localparam logic [2:0] STATUS_CLOSED  = 3'd5;
    localparam logic [2:0] STATUS_FAULT   = 3'd6;

    // Motor drive commands.
    typedef enum logic [1:0] {
        DRV_NONE  = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2,
        DRV_STOP  = 2'd3
    } drive_t;

    // Input word operations.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_OPEN  = 2'd2,
        OP_RESET = 2'd3
    } opcode_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_OPEN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAR_OPEN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_JAM_OPEN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_TIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAR_TIGHT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAR_FOLLOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRONT_FOLLOW = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_WAIT  = 3'd7;

    // Configuration reset values (Q4.12 radians, wait in ms).
    localparam logic signed [15:0] FRONT_OPEN_RST   = 16'sd6649;
    localparam logic signed [15:0] REAR_OPEN_RST    = 16'sd6434;
    localparam logic signed [15:0] JAM_OPEN_RST     = 16'sd1787;
    localparam logic signed [15:0] FRONT_TIGHT_RST  = -16'sd858;
    localparam logic signed [15:0] REAR_TIGHT_RST   = -16'sd1287;
    localparam logic signed [15:0] REAR_FOLLOW_RST  = 16'sd5004;
    localparam logic signed [15:0] FRONT_FOLLOW_RST = 16'sd1430;
    localparam logic [15:0]        SENSOR_WAIT_RST  = 16'd300;

    // Goal of a closing door, minus 100 degrees.
    localparam logic signed [15:0] CLOSE_GOAL = -16'sd7149;

    localparam int unsigned REPORT_PERIOD_DEFAULT = 200;

    typedef struct packed {
        logic signed [15:0] front_open_angle;
        logic signed [15:0] rear_open_angle;
        logic signed [15:0] jam_open_angle;
        logic signed [15:0] front_tight_angle;
        logic signed [15:0] rear_tight_angle;
        logic signed [15:0] rear_close_follow;
        logic signed [15:0] front_open_follow;
        logic [15:0]        sensor_wait_ms;
    } cfg_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [31:0]        now_ms;
        logic               front_closed_seen;
        logic               rear_closed_seen;
        logic               front_overload;
        logic               rear_overload;
        logic signed [15:0] front_angle;
        logic signed [15:0] rear_angle;
    } item_t;

    typedef struct packed {
        door_state_t        mode;
        logic signed [15:0] goal;
        logic               jam;
    } door_t;

    typedef struct packed {
        logic [2:0] front_status;
        logic [2:0] rear_status;
        drive_t     front_drive;
        drive_t     rear_drive;
        logic       front_zero_encoder;
        logic       rear_zero_encoder;
        logic       front_clear_overload;
        logic       rear_clear_overload;
        logic       report_strobe;
    } result_t;

    // Maps the one-hot state to the status code on the result ports.
    function automatic logic [2:0] status_code(door_state_t s);
        logic [2:0] code;
        case (s)
            ST_READY:   code = STATUS_READY;
            ST_OPENED:  code = STATUS_OPENED;
            ST_OPENING: code = STATUS_OPENING;
            ST_CLOSING: code = STATUS_CLOSING;
            ST_TIGHT:   code = STATUS_TIGHT;
            ST_CLOSED:  code = STATUS_CLOSED;
            ST_FAULT:   code = STATUS_FAULT;
            default:    code = STATUS_READY;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/tds_cfg_regs.sv =====
module tds_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [tds_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [15:0]                       wr_data,
    output tds_pkg::cfg_t                     cfg
);

    tds_pkg::cfg_t cfg_reg;
    tds_pkg::cfg_t cfg_next;

    // Decode the write index onto one register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                tds_pkg::CFG_FRONT_OPEN:   cfg_next.front_open_angle  = wr_data;
                tds_pkg::CFG_REAR_OPEN:    cfg_next.rear_open_angle   = wr_data;
                tds_pkg::CFG_JAM_OPEN:     cfg_next.jam_open_angle    = wr_data;
                tds_pkg::CFG_FRONT_TIGHT:  cfg_next.front_tight_angle = wr_data;
                tds_pkg::CFG_REAR_TIGHT:   cfg_next.rear_tight_angle  = wr_data;
                tds_pkg::CFG_REAR_FOLLOW:  cfg_next.rear_close_follow = wr_data;
                tds_pkg::CFG_FRONT_FOLLOW: cfg_next.front_open_follow = wr_data;
                tds_pkg::CFG_SENSOR_WAIT:  cfg_next.sensor_wait_ms    = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.front_open_angle  <= tds_pkg::FRONT_OPEN_RST;
            cfg_reg.rear_open_angle   <= tds_pkg::REAR_OPEN_RST;
            cfg_reg.jam_open_angle    <= tds_pkg::JAM_OPEN_RST;
            cfg_reg.front_tight_angle <= tds_pkg::FRONT_TIGHT_RST;
            cfg_reg.rear_tight_angle  <= tds_pkg::REAR_TIGHT_RST;
            cfg_reg.rear_close_follow <= tds_pkg::REAR_FOLLOW_RST;
            cfg_reg.front_open_follow <= tds_pkg::FRONT_FOLLOW_RST;
            cfg_reg.sensor_wait_ms    <= tds_pkg::SENSOR_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/tds_step.sv =====
module tds_step #(
    parameter int unsigned REPORT_PERIOD_MS = tds_pkg::REPORT_PERIOD_DEFAULT
) (
    input  tds_pkg::cfg_t    cfg,
    input  tds_pkg::item_t   item,
    input  tds_pkg::door_t   front_in,
    input  tds_pkg::door_t   rear_in,
    input  logic [31:0]      last_report_in,
    output tds_pkg::door_t   front_out,
    output tds_pkg::door_t   rear_out,
    output logic [31:0]      last_report_out,
    output tds_pkg::result_t result
);

    localparam logic [31:0] PERIOD = 32'(REPORT_PERIOD_MS);

    tds_pkg::door_t  d0;
    tds_pkg::door_t  d1;
    tds_pkg::drive_t drv0;
    tds_pkg::drive_t drv1;
    logic            z0;
    logic            z1;
    logic            c0;
    logic            c1;
    logic            strobe;
    logic            wait_done;
    logic [31:0]     elapsed;

    assign wait_done = item.now_ms >= {16'd0, cfg.sensor_wait_ms};
    assign elapsed   = item.now_ms - last_report_in;

    // One item: a command, or a tick that runs the front machine and then the rear.
    always_comb
    begin
        d0              = front_in;
        d1              = rear_in;
        drv0            = tds_pkg::DRV_NONE;
        drv1            = tds_pkg::DRV_NONE;
        z0              = 1'b0;
        z1              = 1'b0;
        c0              = 1'b0;
        c1              = 1'b0;
        strobe          = 1'b0;
        last_report_out = last_report_in;

        case (item.opcode)
            tds_pkg::OP_CLOSE:
            begin
                if (d0.mode == tds_pkg::ST_OPENED || d0.mode == tds_pkg::ST_READY)
                begin
                    d0.mode = tds_pkg::ST_CLOSING;
                    d0.goal = tds_pkg::CLOSE_GOAL;
                    c0      = 1'b1;
                    drv0    = tds_pkg::DRV_CLOSE;
                end
            end
            tds_pkg::OP_OPEN:
            begin
                // A door that jammed at power-on reopens a short way first.
                if (d0.mode == tds_pkg::ST_FAULT && d0.jam)
                begin
                    d0.mode = tds_pkg::ST_OPENING;
                    d0.goal = cfg.jam_open_angle;
                    z0      = 1'b1;
                    drv0    = tds_pkg::DRV_OPEN;
                end
                else if (d1.mode == tds_pkg::ST_FAULT && d1.jam)
                begin
                    d1.mode = tds_pkg::ST_OPENING;
                    d1.goal = cfg.jam_open_angle;
                    z1      = 1'b1;
                    drv1    = tds_pkg::DRV_OPEN;
                end
                else if (d1.mode == tds_pkg::ST_CLOSED || d1.mode == tds_pkg::ST_FAULT)
                begin
                    d1.mode = tds_pkg::ST_OPENING;
                    d1.goal = cfg.rear_open_angle;
                    c1      = 1'b1;
                    drv1    = tds_pkg::DRV_OPEN;
                end
            end
            tds_pkg::OP_RESET:
            begin
                if (d0.mode == tds_pkg::ST_FAULT)
                begin
                    d0.mode = tds_pkg::ST_READY;
                    c0      = 1'b1;
                end
                if (d1.mode == tds_pkg::ST_FAULT)
                begin
                    d1.mode = tds_pkg::ST_READY;
                    c1      = 1'b1;
                end
            end
            tds_pkg::OP_TICK:
            begin
                // Front door.
                case (d0.mode)
                    tds_pkg::ST_READY:
                    begin
                        if (wait_done)
                        begin
                            if (item.front_closed_seen)
                            begin
                                z0      = 1'b1;
                                d0.goal = '0;
                                d0.mode = tds_pkg::ST_CLOSED;
                            end
                            else
                            begin
                                d0.mode = tds_pkg::ST_CLOSING;
                                d0.goal = tds_pkg::CLOSE_GOAL;
                                c0      = 1'b1;
                                drv0    = tds_pkg::DRV_CLOSE;
                            end
                        end
                    end
                    tds_pkg::ST_CLOSING:
                    begin
                        if (item.front_overload)
                        begin
                            d0.mode = tds_pkg::ST_FAULT;
                            if (!d0.jam)
                            begin
                                d1.mode = tds_pkg::ST_FAULT;
                            end
                            c0 = 1'b1;
                        end
                        else if (item.front_closed_seen)
                        begin
                            z0      = 1'b1;
                            d0.goal = cfg.front_tight_angle;
                            drv0    = tds_pkg::DRV_CLOSE;
                            d0.mode = tds_pkg::ST_TIGHT;
                        end
                        else if (item.front_angle < cfg.rear_close_follow &&
                                 d1.mode == tds_pkg::ST_OPENED)
                        begin
                            d1.mode = tds_pkg::ST_CLOSING;
                            d1.goal = tds_pkg::CLOSE_GOAL;
                            c1      = 1'b1;
                            drv1    = tds_pkg::DRV_CLOSE;
                        end
                    end
                    tds_pkg::ST_TIGHT:
                    begin
                        if (item.front_overload)
                        begin
                            d0.mode = tds_pkg::ST_FAULT;
                            c0      = 1'b1;
                        end
                        else if (item.front_angle < d0.goal)
                        begin
                            d0.mode = tds_pkg::ST_CLOSED;
                        end
                    end
                    tds_pkg::ST_OPENING:
                    begin
                        if (item.front_overload)
                        begin
                            d0.mode = tds_pkg::ST_FAULT;
                            d1.mode = tds_pkg::ST_FAULT;
                            c0      = 1'b1;
                        end
                        else if (item.front_angle >= d0.goal)
                        begin
                            d0.mode = tds_pkg::ST_OPENED;
                            if (d0.jam)
                            begin
                                d0.mode = tds_pkg::ST_FAULT;
                                d1.mode = tds_pkg::ST_FAULT;
                            end
                        end
                    end
                    tds_pkg::ST_CLOSED:
                    begin
                        d0.jam = 1'b0;
                        drv0   = tds_pkg::DRV_STOP;
                    end
                    tds_pkg::ST_FAULT, tds_pkg::ST_OPENED:
                    begin
                        drv0 = tds_pkg::DRV_STOP;
                    end
                    default:
                    begin
                        drv0 = tds_pkg::DRV_NONE;
                    end
                endcase

                // Rear door, seeing what the front has just done.
                case (d1.mode)
                    tds_pkg::ST_READY:
                    begin
                        if (wait_done)
                        begin
                            if (item.rear_closed_seen)
                            begin
                                z1      = 1'b1;
                                d1.goal = '0;
                                d1.mode = tds_pkg::ST_CLOSED;
                            end
                            else if (d0.mode == tds_pkg::ST_CLOSED)
                            begin
                                d1.mode = tds_pkg::ST_CLOSING;
                                d1.goal = tds_pkg::CLOSE_GOAL;
                                c1      = 1'b1;
                                drv1    = tds_pkg::DRV_CLOSE;
                            end
                        end
                    end
                    tds_pkg::ST_CLOSING:
                    begin
                        if (item.rear_overload)
                        begin
                            d1.mode = tds_pkg::ST_FAULT;
                            if (!d1.jam)
                            begin
                                d0.mode = tds_pkg::ST_FAULT;
                            end
                            c1 = 1'b1;
                        end
                        else if (item.rear_closed_seen)
                        begin
                            z1      = 1'b1;
                            d1.goal = cfg.rear_tight_angle;
                            drv1    = tds_pkg::DRV_CLOSE;
                            d1.mode = tds_pkg::ST_TIGHT;
                        end
                    end
                    tds_pkg::ST_TIGHT:
                    begin
                        if (item.rear_overload)
                        begin
                            d1.mode = tds_pkg::ST_FAULT;
                            c1      = 1'b1;
                        end
                        else if (item.rear_angle < d1.goal)
                        begin
                            d1.mode = tds_pkg::ST_CLOSED;
                        end
                    end
                    tds_pkg::ST_OPENING:
                    begin
                        if (item.rear_overload)
                        begin
                            d0.mode = tds_pkg::ST_FAULT;
                            d1.mode = tds_pkg::ST_FAULT;
                            c1      = 1'b1;
                        end
                        else if (item.rear_angle >= d1.goal)
                        begin
                            d1.mode = tds_pkg::ST_OPENED;
                            if (d1.jam)
                            begin
                                d0.mode = tds_pkg::ST_FAULT;
                                d1.mode = tds_pkg::ST_FAULT;
                            end
                        end
                        else if (item.rear_angle >= cfg.front_open_follow &&
                                 (d0.mode == tds_pkg::ST_CLOSED ||
                                  d0.mode == tds_pkg::ST_FAULT))
                        begin
                            // The front follows the rear open; a front that has
                            // just faulted in this tick counts as faulted here.
                            if (d0.mode == tds_pkg::ST_FAULT && d0.jam)
                            begin
                                d0.goal = cfg.jam_open_angle;
                                z0      = 1'b1;
                            end
                            else
                            begin
                                d0.goal = cfg.front_open_angle;
                                c0      = 1'b1;
                            end
                            d0.mode = tds_pkg::ST_OPENING;
                            drv0    = tds_pkg::DRV_OPEN;
                        end
                    end
                    tds_pkg::ST_CLOSED:
                    begin
                        d1.jam = 1'b0;
                        drv1   = tds_pkg::DRV_STOP;
                    end
                    tds_pkg::ST_FAULT, tds_pkg::ST_OPENED:
                    begin
                        drv1 = tds_pkg::DRV_STOP;
                    end
                    default:
                    begin
                        drv1 = tds_pkg::DRV_NONE;
                    end
                endcase

                // Periodic status report.
                if (elapsed >= PERIOD)
                begin
                    strobe          = 1'b1;
                    last_report_out = item.now_ms;
                end
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

    assign front_out = d0;
    assign rear_out  = d1;

    assign result.front_status         = tds_pkg::status_code(d0.mode);
    assign result.rear_status          = tds_pkg::status_code(d1.mode);
    assign result.front_drive          = drv0;
    assign result.rear_drive           = drv1;
    assign result.front_zero_encoder   = z0;
    assign result.rear_zero_encoder    = z1;
    assign result.front_clear_overload = c0;
    assign result.rear_clear_overload  = c1;
    assign result.report_strobe        = strobe;

endmodule

// ===== rtl/core/two_door_sequencer.sv =====
// Two-door sequencer: runs the front and rear door state machines, one input
// word at a time, and returns one result word for each input word.
// Input channel (in_valid/in_ready): a tick carrying time, sensors, overload
// flags and angles, or a close, open or fault-reset command.
// Output channel (out_valid/out_ready): both door statuses, drive commands,
// encoder and overload clear pulses, and the report strobe.
// Configuration channel (cfg_valid/cfg_ready): register index and 16-bit data,
// always ready; write only while no word is in flight.
// A word accepted into the input register is processed when the result register is
// free, and its result is on the output from then on.
// Throughput: one word per cycle while out_ready is high. The door state
// feeds back through one registered update, so each word sees the state left
// by the previous one. When the receiver stalls, the result register holds and
// one more word may wait in the input register; after that in_ready drops.
// Reset puts both doors in ready with their power-on jam flags set, goals and
// the report time at zero, configuration at its defaults, and both channels
// empty.
module two_door_sequencer #(
    parameter int unsigned REPORT_PERIOD_MS = tds_pkg::REPORT_PERIOD_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic [31:0]                     now_ms,
    input  logic                            front_closed_seen,
    input  logic                            rear_closed_seen,
    input  logic                            front_overload,
    input  logic                            rear_overload,
    input  logic signed [15:0]              front_angle,
    input  logic signed [15:0]              rear_angle,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      front_status,
    output logic [2:0]                      rear_status,
    output logic [1:0]                      front_drive,
    output logic [1:0]                      rear_drive,
    output logic                            front_zero_encoder,
    output logic                            rear_zero_encoder,
    output logic                            front_clear_overload,
    output logic                            rear_clear_overload,
    output logic                            report_strobe,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tds_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);

    tds_pkg::cfg_t    cfg;
    tds_pkg::item_t   item_reg;
    logic             item_valid_reg;
    logic             item_valid_next;
    tds_pkg::door_t   front_reg;
    tds_pkg::door_t   rear_reg;
    logic [31:0]      last_report_reg;
    tds_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    tds_pkg::door_t   front_next;
    tds_pkg::door_t   rear_next;
    logic [31:0]      last_report_next;
    tds_pkg::result_t result_next;

    logic             in_take;
    logic             advance;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    tds_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the held word moves on when the result register is free.
    assign advance         = item_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready        = ~item_valid_reg | advance;
    assign in_take         = in_valid & in_ready;
    assign item_valid_next = in_take | (item_valid_reg & ~advance);
    assign out_valid_next  = advance | (out_valid_reg & ~out_ready);

    // Input register, payload only.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode            <= tds_pkg::opcode_t'(opcode);
            item_reg.now_ms            <= now_ms;
            item_reg.front_closed_seen <= front_closed_seen;
            item_reg.rear_closed_seen  <= rear_closed_seen;
            item_reg.front_overload    <= front_overload;
            item_reg.rear_overload     <= rear_overload;
            item_reg.front_angle       <= front_angle;
            item_reg.rear_angle        <= rear_angle;
        end
    end

    // Door logic for the held word.
    tds_step #(
        .REPORT_PERIOD_MS (REPORT_PERIOD_MS)
    ) u_step (
        .cfg             (cfg),
        .item            (item_reg),
        .front_in        (front_reg),
        .rear_in         (rear_reg),
        .last_report_in  (last_report_reg),
        .front_out       (front_next),
        .rear_out        (rear_next),
        .last_report_out (last_report_next),
        .result          (result_next)
    );

    // Door state and handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            front_reg.mode  <= tds_pkg::ST_READY;
            front_reg.goal  <= '0;
            front_reg.jam   <= 1'b1;
            rear_reg.mode   <= tds_pkg::ST_READY;
            rear_reg.goal   <= '0;
            rear_reg.jam    <= 1'b1;
            last_report_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                front_reg       <= front_next;
                rear_reg        <= rear_next;
                last_report_reg <= last_report_next;
            end
        end
    end

    // Result register, payload only.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign front_status         = result_reg.front_status;
    assign rear_status          = result_reg.rear_status;
    assign front_drive          = result_reg.front_drive;
    assign rear_drive           = result_reg.rear_drive;
    assign front_zero_encoder   = result_reg.front_zero_encoder;
    assign rear_zero_encoder    = result_reg.rear_zero_encoder;
    assign front_clear_overload = result_reg.front_clear_overload;
    assign rear_clear_overload  = result_reg.rear_clear_overload;
    assign report_strobe        = result_reg.report_strobe;

    // A held word with a stalled full result register blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both stages are stalled");

    // Once a door has been seen closed, its jam flag never comes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !front_reg.jam |=> !front_reg.jam)
        else $error("front jam flag set again");

    assert property (@(posedge clk) disable iff (!rst_n)
        !rear_reg.jam |=> !rear_reg.jam)
        else $error("rear jam flag set again");

    // Commands never raise the report strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode != tds_pkg::OP_TICK) |=> !result_reg.report_strobe)
        else $error("report strobe on a command");

    // A processed word always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed word lost");

endmodule
